FILE: design/rmq_pkg.sv
// Shared types and constants for the rotation matrix to quaternion block.
package rmq_pkg;

   localparam int DATA_W        = 16;
   localparam int FRAC_BITS_DEF = 14;

   localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   // quaternion component codes
   localparam logic [1:0] COMP_W = 2'd0;
   localparam logic [1:0] COMP_X = 2'd1;
   localparam logic [1:0] COMP_Y = 2'd2;
   localparam logic [1:0] COMP_Z = 2'd3;

   typedef struct packed {
      logic signed [DATA_W-1:0] m00;
      logic signed [DATA_W-1:0] m01;
      logic signed [DATA_W-1:0] m02;
      logic signed [DATA_W-1:0] m10;
      logic signed [DATA_W-1:0] m11;
      logic signed [DATA_W-1:0] m12;
      logic signed [DATA_W-1:0] m20;
      logic signed [DATA_W-1:0] m21;
      logic signed [DATA_W-1:0] m22;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] qw;
      logic signed [DATA_W-1:0] qx;
      logic signed [DATA_W-1:0] qy;
      logic signed [DATA_W-1:0] qz;
      logic                     invalid;
   } rsp_type;

endpackage

FILE: design/rmq_div_lane.sv
// Pipelined restoring divider lane: rounded n * 2^FRAC_BITS / (2 * root).
module rmq_div_lane #(
   parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
   parameter int RTW       = 16
) (
   input  logic                      clock,
   input  logic                      en,
   input  logic [rmq_pkg::DATA_W:0]  num,
   input  logic [RTW-1:0]            root,
   output logic [rmq_pkg::DATA_W-1:0] quo,
   output logic                      ovf,
   output logic                      neg
);
   import rmq_pkg::*;

   localparam int W  = DATA_W;
   localparam int NW = W + FRAC_BITS + 1;
   localparam int DW = RTW + 1 + W;
   localparam int CW = ((NW > DW) ? NW : DW) + 1;

   logic [CW-1:0]  rem_ff [W+1];
   logic [RTW:0]   d_ff   [W+1];
   logic [W-1:0]   quo_ff [W+1];
   logic [W:0]     ovf_ff;
   logic [W:0]     neg_ff;

   logic [W:0]     mag_in;
   logic [CW-1:0]  rem_in;
   logic [RTW:0]   d_in;
   logic           ovf_in;

   // fold the sign out, add root for round-half-away, flag quotients past W bits
   always_comb begin
      mag_in = num[W] ? (~num + 1'b1) : num;
      rem_in = (CW'(mag_in) << FRAC_BITS) + CW'(root);
      d_in   = {root, 1'b0};
      ovf_in = rem_in >= (CW'(d_in) << W);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= rem_in;
         d_ff[0]   <= d_in;
         quo_ff[0] <= '0;
         ovf_ff[0] <= ovf_in;
         neg_ff[0] <= num[W];
      end
   end

   for (genvar j = 1; j <= W; j++) begin : g_step
      logic [CW-1:0] sh;
      logic          take;
      assign sh   = CW'(d_ff[j-1]) << (W - j);
      assign take = rem_ff[j-1] >= sh;
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= take ? (rem_ff[j-1] - sh) : rem_ff[j-1];
            quo_ff[j] <= quo_ff[j-1] | (take ? (W'(1) << (W - j)) : W'(0));
            d_ff[j]   <= d_ff[j-1];
            ovf_ff[j] <= ovf_ff[j-1];
            neg_ff[j] <= neg_ff[j-1];
         end
      end
   end

   assign quo = quo_ff[W];
   assign ovf = ovf_ff[W];
   assign neg = neg_ff[W];

endmodule

FILE: design/rotation_matrix_to_quaternion.sv
// Top level: fixed-point rotation matrix to quaternion pipeline.
//
//  channel | ports                          | beat
//  --------+--------------------------------+------------------------------------
//  request | req_valid req_ready req_data   | nine signed Q1.14 matrix elements
//  result  | rsp_valid rsp_ready rsp_data   | qw qx qy qz (Q1.14, saturated), invalid
//
// One beat enters per cycle while req_ready is high. The pipe holds one
// decode stage, one square-root stage per root bit (RTW), one divider setup
// stage, one stage per quotient bit, and the output register. Reset clears
// only the valid bits. The whole pipe moves on one enable; a skid entry
// behind the output register catches the beat that leaves the pipe while the
// output is held, and req_ready drops only while that entry is full.
module rotation_matrix_to_quaternion #(
   parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rmq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rmq_pkg::rsp_type rsp_data
);
   import rmq_pkg::*;

   localparam int W     = DATA_W;
   localparam int MAXWF = (W > FRAC_BITS) ? W : FRAC_BITS;
   localparam int ARGW  = MAXWF + 3;
   localparam int RADW  = ARGW - 1 + FRAC_BITS;
   localparam int SQW   = RADW + (RADW % 2);
   localparam int RTW   = SQW / 2;
   localparam int SRW   = RTW + 3;
   localparam int NP    = RTW + W + 2;
   localparam int HRW   = (RTW + 1 > W + 1) ? RTW + 1 : W + 1;

   localparam logic signed [ARGW-1:0] ONE = {{(ARGW-1){1'b0}}, 1'b1} << FRAC_BITS;

   typedef struct packed {
      logic            bad;
      logic [1:0]      hsel;
      logic [2:0][1:0] dst;
      logic [2:0][W:0] num;
   } ctl_type;

   ctl_type        ctl_ff  [NP];
   logic [NP-1:0]  v_ff;
   logic [SQW-1:0] rad_ff  [RTW+1];
   logic [SRW-1:0] srem_ff [RTW+1];
   logic [RTW-1:0] root_ff [NP];

   rsp_type out_ff, skid_ff, fin;
   logic    out_v_ff, skid_v_ff;
   logic    en, out_adv;

   ctl_type        ctl_in;
   logic [SQW-1:0] rad_in;

   // decode: trace, pivot choice, root argument and the three numerators
   logic signed [W+1:0]   trace;
   logic signed [ARGW-1:0] arg;
   logic signed [W-1:0]   dii, djj, dkk;
   logic [1:0]            sel;

   always_comb begin
      trace = (W+2)'(req_data.m00) + (W+2)'(req_data.m11) + (W+2)'(req_data.m22);
      sel   = COMP_X;
      if (req_data.m11 > req_data.m00) sel = COMP_Y;
      if (req_data.m22 > ((sel == COMP_Y) ? req_data.m11 : req_data.m00)) sel = COMP_Z;
      dii = req_data.m00;
      djj = req_data.m11;
      dkk = req_data.m22;
      ctl_in = '0;
      if (trace > 0) begin
         arg           = ARGW'(trace) + ONE;
         ctl_in.hsel   = COMP_W;
         ctl_in.dst[0] = COMP_X;
         ctl_in.dst[1] = COMP_Y;
         ctl_in.dst[2] = COMP_Z;
         ctl_in.num[0] = (W+1)'(req_data.m21) - (W+1)'(req_data.m12);
         ctl_in.num[1] = (W+1)'(req_data.m02) - (W+1)'(req_data.m20);
         ctl_in.num[2] = (W+1)'(req_data.m10) - (W+1)'(req_data.m01);
      end else begin
         ctl_in.hsel   = sel;
         ctl_in.dst[0] = COMP_W;
         unique case (sel)
            COMP_Y: begin
               dii = req_data.m11; djj = req_data.m22; dkk = req_data.m00;
               ctl_in.dst[1] = COMP_Z;
               ctl_in.dst[2] = COMP_X;
               ctl_in.num[0] = (W+1)'(req_data.m02) - (W+1)'(req_data.m20);
               ctl_in.num[1] = (W+1)'(req_data.m21) + (W+1)'(req_data.m12);
               ctl_in.num[2] = (W+1)'(req_data.m01) + (W+1)'(req_data.m10);
            end
            COMP_Z: begin
               dii = req_data.m22; djj = req_data.m00; dkk = req_data.m11;
               ctl_in.dst[1] = COMP_X;
               ctl_in.dst[2] = COMP_Y;
               ctl_in.num[0] = (W+1)'(req_data.m10) - (W+1)'(req_data.m01);
               ctl_in.num[1] = (W+1)'(req_data.m02) + (W+1)'(req_data.m20);
               ctl_in.num[2] = (W+1)'(req_data.m12) + (W+1)'(req_data.m21);
            end
            default: begin
               ctl_in.dst[1] = COMP_Y;
               ctl_in.dst[2] = COMP_Z;
               ctl_in.num[0] = (W+1)'(req_data.m21) - (W+1)'(req_data.m12);
               ctl_in.num[1] = (W+1)'(req_data.m10) + (W+1)'(req_data.m01);
               ctl_in.num[2] = (W+1)'(req_data.m20) + (W+1)'(req_data.m02);
            end
         endcase
         arg = ARGW'(dii) - ARGW'(djj) - ARGW'(dkk) + ONE;
      end
      ctl_in.bad = (arg <= 0);
      rad_in     = ctl_in.bad ? '0 : (SQW'(arg[ARGW-2:0]) << FRAC_BITS);
   end

   // advance the pipe unless the skid entry holds a beat
   assign en        = !skid_v_ff;
   assign req_ready = en;
   assign out_adv   = !out_v_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[NP-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctl_ff[0]  <= ctl_in;
         rad_ff[0]  <= rad_in;
         srem_ff[0] <= '0;
         root_ff[0] <= '0;
         for (int k = 1; k < NP; k++) ctl_ff[k] <= ctl_ff[k-1];
      end
   end

   // square root, one root bit per stage
   for (genvar k = 1; k <= RTW; k++) begin : g_sqrt
      logic [SRW-1:0] cur, trial;
      logic           take;
      assign cur   = {srem_ff[k-1][SRW-3:0], rad_ff[k-1][SQW-1 -: 2]};
      assign trial = SRW'({root_ff[k-1], 2'b01});
      assign take  = cur >= trial;
      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[k]  <= rad_ff[k-1] << 2;
            srem_ff[k] <= take ? (cur - trial) : cur;
            root_ff[k] <= {root_ff[k-1][RTW-2:0], take};
         end
      end
   end

   for (genvar k = RTW + 1; k < NP; k++) begin : g_root
      always_ff @(posedge clock) begin
         if (en) root_ff[k] <= root_ff[k-1];
      end
   end

   // three divider lanes, aligned with the last pipe stage
   logic [2:0][W-1:0] quo;
   logic [2:0]        ovf, neg;

   for (genvar l = 0; l < 3; l++) begin : g_lane
      rmq_div_lane #(
         .FRAC_BITS (FRAC_BITS),
         .RTW       (RTW)
      ) u_lane (
         .clock (clock),
         .en    (en),
         .num   (ctl_ff[RTW].num[l]),
         .root  (root_ff[RTW]),
         .quo   (quo[l]),
         .ovf   (ovf[l]),
         .neg   (neg[l])
      );
   end

   // saturate, steer lanes and the half-root to their components
   logic [HRW-1:0]        hr_ext;
   logic [W-1:0]          hr;
   logic [3:0][W-1:0]     comp;
   logic [2:0][W-1:0]     lval;

   always_comb begin
      hr_ext = (HRW'(root_ff[NP-1]) + 1'b1) >> 1;
      hr     = (hr_ext > HRW'(SAT_MAX)) ? SAT_MAX : hr_ext[W-1:0];
      comp   = '0;
      for (int l = 0; l < 3; l++) begin
         if (neg[l]) lval[l] = (ovf[l] || quo[l][W-1]) ? SAT_MIN : (~quo[l] + 1'b1);
         else        lval[l] = (ovf[l] || quo[l][W-1]) ? SAT_MAX : quo[l];
         comp[ctl_ff[NP-1].dst[l]] = lval[l];
      end
      comp[ctl_ff[NP-1].hsel] = hr;
      if (ctl_ff[NP-1].bad) comp = '0;
      fin.qw      = comp[COMP_W];
      fin.qx      = comp[COMP_X];
      fin.qy      = comp[COMP_Y];
      fin.qz      = comp[COMP_Z];
      fin.invalid = ctl_ff[NP-1].bad;
   end

   // output register with one skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         if (out_adv) begin
            out_v_ff  <= skid_v_ff || (en && v_ff[NP-1]);
            skid_v_ff <= 1'b0;
         end else if (en && v_ff[NP-1]) begin
            skid_v_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv) begin
         out_ff <= skid_v_ff ? skid_ff : fin;
      end else if (en && v_ff[NP-1]) begin
         skid_ff <= fin;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.invalid |->
         rsp_data.qw == '0 && rsp_data.qx == '0 && rsp_data.qy == '0 && rsp_data.qz == '0)
      else $error("invalid result carries nonzero components");

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid entry full while output register empty");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> v_ff[0])
      else $error("accepted beat missing from decode stage");

   a_skid_fill_stalls: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && !rsp_ready && !skid_v_ff && v_ff[NP-1] |=> !req_ready)
      else $error("pipe kept running after skid entry filled");

endmodule

FILE: tb/tb_top.sv
// Testbench for the rotation matrix to quaternion pipeline.
module tb_top;
   import rmq_pkg::*;

   localparam int FRAC      = FRAC_BITS_DEF;
   localparam int LATENCY   = 40;
   localparam int STALL_MAX = 5000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   req_type matrix_queue[$];
   rsp_type quat_queue[$];
   int      mismatches;
   int      idle_count;
   bit      calm;
   int      hold_left;
   bit      hold_armed;
   int      rsp_count;

   rotation_matrix_to_quaternion i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Integer square root, floor.
   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // n * ONE / (2 * root), rounded to nearest with ties away from zero.
   function automatic longint scaled_quot(longint n, longint unsigned root);
      longint unsigned mag;
      longint unsigned q;
      mag = (n < 0) ? longint'(-n) : longint'(n);
      q   = ((mag << FRAC) + root) / (root * 2);
      return (n < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic signed [DATA_W-1:0] clip(longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) << (DATA_W - 1)) - 1;
      lo = -(longint'(1) << (DATA_W - 1));
      if (v > hi) return SAT_MAX;
      if (v < lo) return SAT_MIN;
      return v[DATA_W-1:0];
   endfunction

   function automatic rsp_type quat_of(req_type a);
      longint m[3][3];
      longint q[4];
      longint one;
      longint trace;
      longint arg;
      longint unsigned root;
      int i;
      int j;
      int k;
      rsp_type r;
      m[0][0] = a.m00; m[0][1] = a.m01; m[0][2] = a.m02;
      m[1][0] = a.m10; m[1][1] = a.m11; m[1][2] = a.m12;
      m[2][0] = a.m20; m[2][1] = a.m21; m[2][2] = a.m22;
      one   = longint'(1) << FRAC;
      trace = m[0][0] + m[1][1] + m[2][2];
      r     = '0;
      if (trace > 0) begin
         arg  = trace + one;
         root = floor_sqrt(longint'(arg) << FRAC);
         q[0] = (root + 1) >> 1;
         q[1] = scaled_quot(m[2][1] - m[1][2], root);
         q[2] = scaled_quot(m[0][2] - m[2][0], root);
         q[3] = scaled_quot(m[1][0] - m[0][1], root);
      end else begin
         // strict compares: lower index wins on ties
         i = 0;
         if (m[1][1] > m[0][0]) i = 1;
         if (m[2][2] > m[i][i]) i = 2;
         j = (i + 1) % 3;
         k = (j + 1) % 3;
         arg = m[i][i] - m[j][j] - m[k][k] + one;
         if (arg <= 0) begin
            r.invalid = 1'b1;
            return r;
         end
         root     = floor_sqrt(longint'(arg) << FRAC);
         q[1 + i] = (root + 1) >> 1;
         q[0]     = scaled_quot(m[k][j] - m[j][k], root);
         q[1 + j] = scaled_quot(m[j][i] + m[i][j], root);
         q[1 + k] = scaled_quot(m[k][i] + m[i][k], root);
      end
      r.qw = clip(q[COMP_W]);
      r.qx = clip(q[COMP_X]);
      r.qy = clip(q[COMP_Y]);
      r.qz = clip(q[COMP_Z]);
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      mismatches++;
      $display("mismatch on %s: got %0d, expected %0d", what, got, want);
   endtask

   function automatic logic [DATA_W-1:0] rand_elem();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 5) return DATA_W'($urandom_range(0, 2 ** (FRAC + 1)) - 2 ** FRAC);
      if (sel < 7) return DATA_W'($urandom_range(0, 64) - 32 + 2 ** FRAC);
      return DATA_W'($urandom);
   endfunction

   // Build a random matrix from independently drawn elements; mix in pure noise.
   function automatic req_type rand_matrix();
      req_type a;
      a.m00 = rand_elem(); a.m01 = rand_elem(); a.m02 = rand_elem();
      a.m10 = rand_elem(); a.m11 = rand_elem(); a.m12 = rand_elem();
      a.m20 = rand_elem(); a.m21 = rand_elem(); a.m22 = rand_elem();
      if ($urandom_range(0, 3) == 0) begin
         // force one diagonal element to one
         case ($urandom_range(0, 2))
            0: a.m00 = DATA_W'(2 ** FRAC);
            1: a.m11 = DATA_W'(2 ** FRAC);
            default: a.m22 = DATA_W'(2 ** FRAC);
         endcase
      end
      return a;
   endfunction

   function automatic req_type diag_matrix(int d0, int d1, int d2, int off);
      req_type a;
      a     = '0;
      a.m00 = DATA_W'(d0); a.m11 = DATA_W'(d1); a.m22 = DATA_W'(d2);
      a.m01 = DATA_W'(off); a.m10 = DATA_W'(-off); a.m12 = DATA_W'(off);
      a.m21 = DATA_W'(off); a.m02 = DATA_W'(-off);
      a.m20 = DATA_W'(off);
      return a;
   endfunction

   initial begin
      req_type a;
      int one;
      one = 2 ** FRAC;
      // identity, positive trace
      matrix_queue.push_back(diag_matrix(one, one, one, 0));
      // half-turns about each axis: each diagonal index wins once
      matrix_queue.push_back(diag_matrix(one, -one, -one, 0));
      matrix_queue.push_back(diag_matrix(-one, one, -one, 0));
      matrix_queue.push_back(diag_matrix(-one, -one, one, 0));
      // ties on the diagonal
      matrix_queue.push_back(diag_matrix(0, 0, 0, 100));
      matrix_queue.push_back(diag_matrix(-100, -100, -100, 50));
      matrix_queue.push_back(diag_matrix(-one, -one, -one, 0));
      // extreme diagonal values
      matrix_queue.push_back(diag_matrix(-32768, 32767, 32767, 7));
      matrix_queue.push_back(diag_matrix(-32768, -32768, -32768, 0));
      // extremes, saturation
      matrix_queue.push_back(diag_matrix(32767, 32767, 32767, -32768));
      matrix_queue.push_back(diag_matrix(1, 0, 0, 32767));
      a = '1;
      matrix_queue.push_back(a);
      a = '0;
      matrix_queue.push_back(a);
      a = {9{16'sh8000}};
      matrix_queue.push_back(a);
      a = {9{16'sh7fff}};
      matrix_queue.push_back(a);
      a = {9{16'sh5555}};
      matrix_queue.push_back(a);
      a = {9{16'shaaaa}};
      matrix_queue.push_back(a);
      repeat (700) matrix_queue.push_back(rand_matrix());
   end

   // Stall pattern: calm window in the middle, one long hold-off early on.
   always_ff @(posedge clock) begin
      if (reset) begin
         calm       <= 1'b0;
         hold_left  <= 0;
         hold_armed <= 1'b1;
      end else begin
         calm <= (rsp_count > 300 && rsp_count < 450);
         if (hold_armed && rsp_count == 50) begin
            hold_left  <= 200;
            hold_armed <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
         end
      end
   end

   // Driver: offer the next matrix, hold it until accepted.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
      end else if (!req_valid || req_ready) begin
         if (matrix_queue.size() > 0 && (calm || $urandom_range(0, 99) >= 8)) begin
            req_valid <= 1'b1;
            req_data  <= matrix_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Predict at acceptance.
   always_ff @(posedge clock) begin
      if (!reset && req_valid && req_ready) quat_queue.push_back(quat_of(req_data));
   end

   // Monitor: drive ready, check each accepted result beat.
   always_ff @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_count <= 0;
      end else begin
         rsp_ready <= (hold_left == 0) && (calm || $urandom_range(0, 99) >= 8);
         if (rsp_valid && rsp_ready) begin
            rsp_count <= rsp_count + 1;
            if (quat_queue.size() == 0) begin
               report_mismatch("unexpected beat", 1, 0);
            end else begin
               want = quat_queue.pop_front();
               if (rsp_data.qw !== want.qw) report_mismatch("qw", rsp_data.qw, want.qw);
               if (rsp_data.qx !== want.qx) report_mismatch("qx", rsp_data.qx, want.qx);
               if (rsp_data.qy !== want.qy) report_mismatch("qy", rsp_data.qy, want.qy);
               if (rsp_data.qz !== want.qz) report_mismatch("qz", rsp_data.qz, want.qz);
               if (rsp_data.invalid !== want.invalid)
                  report_mismatch("invalid", rsp_data.invalid, want.invalid);
            end
         end
      end
   end

   // Watchdog: count cycles with no beat on either side.
   always_ff @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_count <= 0;
      end else begin
         idle_count <= idle_count + 1;
         if (idle_count >= STALL_MAX) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      reset      = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (matrix_queue.size() != 0 || req_valid || quat_queue.size() != 0)
         @(posedge clock);
      repeat (LATENCY) @(posedge clock);
      if (mismatches == 0 && quat_queue.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule

FILE: files.f
design/rmq_pkg.sv
design/rmq_div_lane.sv
design/rotation_matrix_to_quaternion.sv
tb/tb_top.sv
